>>> src/maglev_lookup_table_builder_unit_defines.svh
// Assertion macros used by the checker file of the maglev table builder
`ifndef MAGLEV_LOOKUP_TABLE_BUILDER_UNIT_DEFINES_SVH
`define MAGLEV_LOOKUP_TABLE_BUILDER_UNIT_DEFINES_SVH

// Clocked assertion, switched off while reset is held
`define MLT_ASSERT(lbl, clk, rstn, prop, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rstn) prop) else $error(msg);

// Clocked assertion that also holds through reset
`define MLT_ASSERT_ALWAYS(lbl, clk, prop, msg) \
  lbl: assert property (@(posedge clk) prop) else $error(msg);

`endif

>>> src/mlt_pkg.sv
// Types and constants of the maglev table builder
package mlt_pkg;

  localparam int TABLE_DEPTH  = 8192;
  localparam int SLOT_AW      = 13;
  localparam int MAX_BACKENDS = 64;
  localparam int BK_AW        = 6;
  localparam int CNT_W        = 7;
  localparam int ID_BITS      = 16;
  localparam int HASH_W       = 32;
  localparam int FLOW_W       = 64;
  localparam int SIZE_W       = 13;
  localparam int SLOT_W       = 17;
  localparam int REM_STEPS_W  = 7;

  localparam logic [SIZE_W-1:0] SIZE_RESET = 13'd4093;
  localparam logic [SLOT_W-1:0] SLOT_EMPTY = '1;

  typedef enum logic [1:0] {
    OP_CLEAR  = 2'd0,
    OP_LOAD   = 2'd1,
    OP_BUILD  = 2'd2,
    OP_LOOKUP = 2'd3
  } op_t;

  typedef enum logic [1:0] {
    STAT_OK    = 2'd0,
    STAT_FULL  = 2'd1,
    STAT_PROBE = 2'd2
  } stat_t;

  typedef enum logic [3:0] {
    ST_CLR,
    ST_IDLE,
    ST_LD_RD,
    ST_LD_CMP,
    ST_LD_WR,
    ST_PR_RD,
    ST_PR_OFF,
    ST_PR_OWAIT,
    ST_PR_SWAIT,
    ST_FL_RD,
    ST_FL_ADDR,
    ST_FL_CHK,
    ST_LU_WAIT,
    ST_LU_RD,
    ST_DONE
  } state_t;

  // backend list entry
  typedef struct packed {
    logic [ID_BITS-1:0] id;
    logic [HASH_W-1:0]  oh;
    logic [HASH_W-1:0]  sh;
  } list_ent_t;

  // per-backend permutation state during a build
  typedef struct packed {
    logic [SIZE_W-1:0] skip;
    logic [SIZE_W-1:0] cur;
  } bk_ent_t;

  // request to the remainder unit
  typedef struct packed {
    logic              start;
    logic [SIZE_W-1:0] divisor;
  } rem_ctl_t;

endpackage

>>> src/mlt_if.sv
// Item channels of the maglev table builder
interface mlt_in_if;
  logic                          valid;
  logic                          ready;
  logic [1:0]                    opcode;
  logic [mlt_pkg::ID_BITS-1:0]   server_id;
  logic [mlt_pkg::HASH_W-1:0]    offset_hash;
  logic [mlt_pkg::HASH_W-1:0]    skip_hash;
  logic [mlt_pkg::FLOW_W-1:0]    flow_digest;
  modport source (output valid, opcode, server_id, offset_hash, skip_hash, flow_digest,
                  input ready);
  modport sink (input valid, opcode, server_id, offset_hash, skip_hash, flow_digest,
                output ready);
endinterface

interface mlt_out_if;
  logic                             valid;
  logic                             ready;
  logic [1:0]                       status;
  logic signed [mlt_pkg::SLOT_W-1:0] chosen_backend;
  logic [mlt_pkg::SIZE_W-1:0]       bucket;
  modport source (output valid, status, chosen_backend, bucket, input ready);
  modport sink (input valid, status, chosen_backend, bucket, output ready);
endinterface

>>> src/mlt_ram.sv
// Simple dual-port RAM with registered read data
module mlt_ram #(
  parameter int DEPTH = 64,
  parameter int WIDTH = 8
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic                     re,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);
  logic [WIDTH-1:0] mem [DEPTH];
  logic [WIDTH-1:0] rdata_r;

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    if (re) begin
      rdata_r <= mem[raddr];
    end
  end

  assign rdata = rdata_r;
endmodule

>>> src/mlt_rem.sv
// Bit-serial remainder unit: 64-bit dividend by a 13-bit divisor, one bit a cycle
module mlt_rem (
  input  logic                          clk,
  input  logic                          rst_n,
  input  mlt_pkg::rem_ctl_t             ctl,
  input  logic [mlt_pkg::FLOW_W-1:0]    dividend,
  output logic                          done,
  output logic [mlt_pkg::SIZE_W-1:0]    rem
);
  import mlt_pkg::*;

  logic                   busy_r, done_r;
  logic [REM_STEPS_W-1:0] cnt_r;
  logic [FLOW_W-1:0]      dvd_r;
  logic [SIZE_W-1:0]      div_r, rem_r;
  logic [SIZE_W:0]        trial;
  logic [SIZE_W:0]        rem_nxt;

  // restoring step: shift in the next dividend bit, subtract if it fits
  always_comb begin
    trial = {rem_r, dvd_r[FLOW_W-1]};
    if (trial >= {1'b0, div_r}) begin
      rem_nxt = trial - {1'b0, div_r};
    end else begin
      rem_nxt = trial;
    end
  end

  // control
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r <= 1'b0;
      done_r <= 1'b0;
      cnt_r  <= '0;
    end else begin
      done_r <= 1'b0;
      if (ctl.start) begin
        busy_r <= 1'b1;
        cnt_r  <= REM_STEPS_W'(FLOW_W);
      end else if (busy_r) begin
        cnt_r <= cnt_r - 1'b1;
        if (cnt_r == REM_STEPS_W'(1)) begin
          busy_r <= 1'b0;
          done_r <= 1'b1;
        end
      end
    end
  end

  // datapath
  always_ff @(posedge clk) begin
    if (ctl.start) begin
      dvd_r <= dividend;
      div_r <= ctl.divisor;
      rem_r <= '0;
    end else if (busy_r) begin
      dvd_r <= {dvd_r[FLOW_W-2:0], 1'b0};
      rem_r <= rem_nxt[SIZE_W-1:0];
    end
  end

  assign done = done_r;
  assign rem  = rem_r;
endmodule

>>> src/maglev_lookup_table_builder_unit.sv
// Maglev consistent-hash table: backend list, table build and flow lookup
//
//  channel  | dir | handshake          | payload
//  ---------+-----+--------------------+---------------------------------------------
//  in_ch    | in  | valid/ready        | opcode, server_id, offset_hash, skip_hash,
//           |     |                    | flow_digest
//  out_ch   | out | valid/ready        | status, chosen_backend, bucket
//  cfg_*    | in  | APB psel/penable   | table_size at byte address 0
//
// One item at a time; in_ch.ready is high only while idle. Lookup runs the serial
// remainder of flow_digest by the table size, then reads the slot it names. Load
// answers at once when the list is full, else moves larger entries up one place,
// one entry a cycle, to insert the new one in id order. Clear empties the list
// and sweeps the slot table. Build sweeps the slot table, takes the offset and
// skip remainders per backend, then places backends in turn. After reset a sweep
// empties the slot table before the first item is taken. A stalled result is held
// in the output register and the next item is accepted meanwhile.
module maglev_lookup_table_builder_unit (
  input  logic                        clk,
  input  logic                        rst_n,
  mlt_in_if.sink                      in_ch,
  mlt_out_if.source                   out_ch,
  input  logic                        cfg_psel,
  input  logic                        cfg_penable,
  input  logic                        cfg_pwrite,
  input  logic [1:0]                  cfg_paddr,
  input  logic [31:0]                 cfg_pwdata,
  output logic [31:0]                 cfg_prdata,
  output logic                        cfg_pready
);
  import mlt_pkg::*;

  state_t              state_r, state_nxt;
  logic [SIZE_W-1:0]   size_r;
  logic [CNT_W-1:0]    cnt_r, cnt_nxt;
  logic [CNT_W-1:0]    pos_r, pos_nxt;
  logic [CNT_W-1:0]    bidx_r, bidx_nxt;
  logic [SIZE_W-1:0]   fill_r, fill_nxt;
  logic [SIZE_W-1:0]   tries_r, tries_nxt;
  logic [SIZE_W-1:0]   c_r, c_nxt;
  logic [SIZE_W-1:0]   off_r, off_nxt;
  logic [SLOT_AW-1:0]  clr_r, clr_nxt;
  logic                build_r, build_nxt;
  logic                init_r;
  logic [ID_BITS-1:0]  id_r, id_nxt;
  logic [HASH_W-1:0]   oh_r, oh_nxt, sh_r, sh_nxt;
  stat_t               stat_r, stat_nxt;
  logic [SLOT_W-1:0]   chosen_r, chosen_nxt;
  logic [SIZE_W-1:0]   bucket_r, bucket_nxt;
  logic                out_vld_r;
  logic [1:0]          out_stat_r;
  logic [SLOT_W-1:0]   out_chosen_r;
  logic [SIZE_W-1:0]   out_bucket_r;

  logic                in_acc, out_load;
  logic [SIZE_W-1:0]   m, m_dec;
  logic [CNT_W-1:0]    pos_dec, pos_dec2, bidx_inc;
  logic [SIZE_W:0]     c_sum, c_next_w;
  logic [SIZE_W-1:0]   c_next;
  logic                id_gt, slot_empty, last_fill, probe_fail, last_bk;

  // memories
  logic                list_we, list_re;
  logic [BK_AW-1:0]    list_waddr, list_raddr;
  list_ent_t           list_wdata, list_rdata;
  logic                bk_we, bk_re;
  logic [BK_AW-1:0]    bk_waddr, bk_raddr;
  bk_ent_t             bk_wdata, bk_rdata;
  logic                slot_we, slot_re;
  logic [SLOT_AW-1:0]  slot_waddr, slot_raddr;
  logic [SLOT_W-1:0]   slot_wdata, slot_rdata;

  // remainder unit
  rem_ctl_t            rem_ctl;
  logic [FLOW_W-1:0]   rem_dvd;
  logic                rem_done;
  logic [SIZE_W-1:0]   rem_val;

  mlt_ram #(.DEPTH(MAX_BACKENDS), .WIDTH($bits(list_ent_t))) u_list (
    .clk, .we(list_we), .waddr(list_waddr), .wdata(list_wdata),
    .re(list_re), .raddr(list_raddr), .rdata(list_rdata)
  );

  mlt_ram #(.DEPTH(MAX_BACKENDS), .WIDTH($bits(bk_ent_t))) u_bk (
    .clk, .we(bk_we), .waddr(bk_waddr), .wdata(bk_wdata),
    .re(bk_re), .raddr(bk_raddr), .rdata(bk_rdata)
  );

  mlt_ram #(.DEPTH(TABLE_DEPTH), .WIDTH(SLOT_W)) u_slot (
    .clk, .we(slot_we), .waddr(slot_waddr), .wdata(slot_wdata),
    .re(slot_re), .raddr(slot_raddr), .rdata(slot_rdata)
  );

  mlt_rem u_rem (
    .clk, .rst_n, .ctl(rem_ctl), .dividend(rem_dvd), .done(rem_done), .rem(rem_val)
  );

  // config port
  assign cfg_pready = 1'b1;
  assign cfg_prdata = {{(32-SIZE_W){1'b0}}, size_r};

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      size_r <= SIZE_RESET;
    end else if (cfg_psel && cfg_penable && cfg_pwrite && cfg_paddr == 2'd0) begin
      size_r <= cfg_pwdata[SIZE_W-1:0];
    end
  end

  // shared terms
  assign m          = (size_r < SIZE_W'(2)) ? SIZE_W'(2) : size_r;
  assign m_dec      = m - 1'b1;
  assign in_acc     = in_ch.valid && in_ch.ready;
  assign out_load   = (state_r == ST_DONE) && (!out_vld_r || out_ch.ready);
  assign pos_dec    = pos_r - 1'b1;
  assign pos_dec2   = pos_r - CNT_W'(2);
  assign bidx_inc   = bidx_r + 1'b1;
  assign last_bk    = (bidx_inc == cnt_r);
  assign id_gt      = list_rdata.id > id_r;
  assign slot_empty = (slot_rdata == SLOT_EMPTY);
  assign c_sum      = {1'b0, c_r} + {1'b0, bk_rdata.skip};
  assign c_next_w   = (c_sum >= {1'b0, m}) ? (c_sum - {1'b0, m}) : c_sum;
  assign c_next     = c_next_w[SIZE_W-1:0];
  assign last_fill  = ((fill_r + 1'b1) == m);
  assign probe_fail = ({1'b0, tries_r} + 1'b1) >= {1'b0, m};

  // next state
  always_comb begin
    state_nxt = state_r;
    unique case (state_r)
      ST_CLR: begin
        if (clr_r == SLOT_AW'(TABLE_DEPTH - 1)) begin
          // the sweep after reset answers no item
          if (init_r) begin
            state_nxt = ST_IDLE;
          end else if (build_r && cnt_r != '0) begin
            state_nxt = ST_PR_RD;
          end else begin
            state_nxt = ST_DONE;
          end
        end
      end
      ST_IDLE: begin
        if (in_acc) begin
          unique case (op_t'(in_ch.opcode))
            OP_CLEAR, OP_BUILD: state_nxt = ST_CLR;
            OP_LOAD: begin
              if (cnt_r == CNT_W'(MAX_BACKENDS)) begin
                state_nxt = ST_DONE;
              end else if (cnt_r == '0) begin
                state_nxt = ST_LD_WR;
              end else begin
                state_nxt = ST_LD_RD;
              end
            end
            OP_LOOKUP: state_nxt = ST_LU_WAIT;
            default:   state_nxt = ST_IDLE;
          endcase
        end
      end
      ST_LD_RD:  state_nxt = ST_LD_CMP;
      ST_LD_CMP: begin
        if (!id_gt) begin
          state_nxt = ST_DONE;
        end else if (pos_r == CNT_W'(1)) begin
          state_nxt = ST_LD_WR;
        end
      end
      ST_LD_WR:    state_nxt = ST_DONE;
      ST_PR_RD:    state_nxt = ST_PR_OFF;
      ST_PR_OFF:   state_nxt = ST_PR_OWAIT;
      ST_PR_OWAIT: if (rem_done) state_nxt = ST_PR_SWAIT;
      ST_PR_SWAIT: begin
        if (rem_done) begin
          state_nxt = last_bk ? ST_FL_RD : ST_PR_RD;
        end
      end
      ST_FL_RD:   state_nxt = ST_FL_ADDR;
      ST_FL_ADDR: state_nxt = ST_FL_CHK;
      ST_FL_CHK: begin
        if (slot_empty) begin
          state_nxt = last_fill ? ST_DONE : ST_FL_RD;
        end else if (probe_fail) begin
          state_nxt = ST_DONE;
        end
      end
      ST_LU_WAIT: if (rem_done) state_nxt = ST_LU_RD;
      ST_LU_RD:   state_nxt = ST_DONE;
      ST_DONE:    if (out_load) state_nxt = ST_IDLE;
      default:    state_nxt = ST_IDLE;
    endcase
  end

  // datapath and memory controls
  always_comb begin
    cnt_nxt    = cnt_r;
    pos_nxt    = pos_r;
    bidx_nxt   = bidx_r;
    fill_nxt   = fill_r;
    tries_nxt  = tries_r;
    c_nxt      = c_r;
    off_nxt    = off_r;
    clr_nxt    = clr_r;
    build_nxt  = build_r;
    id_nxt     = id_r;
    oh_nxt     = oh_r;
    sh_nxt     = sh_r;
    stat_nxt   = stat_r;
    chosen_nxt = chosen_r;
    bucket_nxt = bucket_r;
    list_we    = 1'b0;
    list_waddr = pos_r[BK_AW-1:0];
    list_wdata = '{id: id_r, oh: oh_r, sh: sh_r};
    list_re    = 1'b0;
    list_raddr = bidx_r[BK_AW-1:0];
    bk_we      = 1'b0;
    bk_waddr   = bidx_r[BK_AW-1:0];
    bk_wdata   = '{skip: bk_rdata.skip, cur: c_next};
    bk_re      = 1'b0;
    bk_raddr   = bidx_r[BK_AW-1:0];
    slot_we    = 1'b0;
    slot_waddr = c_r;
    slot_wdata = {1'b0, id_r};
    slot_re    = 1'b0;
    slot_raddr = c_next;
    rem_ctl    = '{start: 1'b0, divisor: m};
    rem_dvd    = {{(FLOW_W-HASH_W){1'b0}}, list_rdata.oh};
    unique case (state_r)
      ST_CLR: begin
        slot_we    = 1'b1;
        slot_waddr = clr_r;
        slot_wdata = SLOT_EMPTY;
        clr_nxt    = clr_r + 1'b1;
        bidx_nxt   = '0;
      end
      ST_IDLE: begin
        if (in_acc) begin
          id_nxt     = in_ch.server_id;
          oh_nxt     = in_ch.offset_hash;
          sh_nxt     = in_ch.skip_hash;
          stat_nxt   = STAT_OK;
          chosen_nxt = '0;
          bucket_nxt = '0;
          clr_nxt    = '0;
          pos_nxt    = cnt_r;
          unique case (op_t'(in_ch.opcode))
            OP_CLEAR: begin
              cnt_nxt   = '0;
              build_nxt = 1'b0;
            end
            OP_BUILD: build_nxt = 1'b1;
            OP_LOAD: begin
              if (cnt_r == CNT_W'(MAX_BACKENDS)) begin
                stat_nxt = STAT_FULL;
              end
            end
            OP_LOOKUP: begin
              rem_ctl.start = 1'b1;
              rem_dvd       = in_ch.flow_digest;
            end
            default: ;
          endcase
        end
      end
      ST_LD_RD: begin
        list_re    = 1'b1;
        list_raddr = pos_dec[BK_AW-1:0];
      end
      ST_LD_CMP: begin
        if (id_gt) begin
          // move the larger entry up one place and look one further down
          list_we    = 1'b1;
          list_wdata = list_rdata;
          pos_nxt    = pos_dec;
          list_re    = 1'b1;
          list_raddr = pos_dec2[BK_AW-1:0];
        end else begin
          list_we = 1'b1;
          cnt_nxt = cnt_r + 1'b1;
        end
      end
      ST_LD_WR: begin
        list_we = 1'b1;
        cnt_nxt = cnt_r + 1'b1;
      end
      ST_PR_RD: list_re = 1'b1;
      ST_PR_OFF: rem_ctl.start = 1'b1;
      ST_PR_OWAIT: begin
        if (rem_done) begin
          off_nxt       = rem_val;
          rem_ctl       = '{start: 1'b1, divisor: m_dec};
          rem_dvd       = {{(FLOW_W-HASH_W){1'b0}}, list_rdata.sh};
        end
      end
      ST_PR_SWAIT: begin
        if (rem_done) begin
          bk_we    = 1'b1;
          bk_wdata = '{skip: rem_val + 1'b1, cur: off_r};
          bidx_nxt = last_bk ? '0 : bidx_inc;
          fill_nxt = '0;
        end
      end
      ST_FL_RD: begin
        list_re = 1'b1;
        bk_re   = 1'b1;
      end
      ST_FL_ADDR: begin
        c_nxt      = bk_rdata.cur;
        slot_re    = 1'b1;
        slot_raddr = bk_rdata.cur;
        tries_nxt  = '0;
      end
      ST_FL_CHK: begin
        if (slot_empty) begin
          // take the slot, advance this backend's permutation
          slot_we    = 1'b1;
          slot_wdata = {1'b0, list_rdata.id};
          bk_we      = 1'b1;
          fill_nxt   = fill_r + 1'b1;
          bidx_nxt   = last_bk ? '0 : bidx_inc;
        end else if (probe_fail) begin
          stat_nxt = STAT_PROBE;
        end else begin
          tries_nxt = tries_r + 1'b1;
          c_nxt     = c_next;
          slot_re   = 1'b1;
        end
      end
      ST_LU_WAIT: begin
        if (rem_done) begin
          bucket_nxt = rem_val;
          slot_re    = 1'b1;
          slot_raddr = rem_val;
        end
      end
      ST_LU_RD: chosen_nxt = slot_rdata;
      ST_DONE: ;
      default: ;
    endcase
  end

  // control registers
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r   <= ST_CLR;
      cnt_r     <= '0;
      clr_r     <= '0;
      build_r   <= 1'b0;
      init_r    <= 1'b1;
      out_vld_r <= 1'b0;
    end else begin
      state_r <= state_nxt;
      cnt_r   <= cnt_nxt;
      clr_r   <= clr_nxt;
      build_r <= build_nxt;
      if (state_r == ST_IDLE) begin
        init_r <= 1'b0;
      end
      if (out_load) begin
        out_vld_r <= 1'b1;
      end else if (out_ch.ready) begin
        out_vld_r <= 1'b0;
      end
    end
  end

  // payload registers
  always_ff @(posedge clk) begin
    pos_r    <= pos_nxt;
    bidx_r   <= bidx_nxt;
    fill_r   <= fill_nxt;
    tries_r  <= tries_nxt;
    c_r      <= c_nxt;
    off_r    <= off_nxt;
    id_r     <= id_nxt;
    oh_r     <= oh_nxt;
    sh_r     <= sh_nxt;
    stat_r   <= stat_nxt;
    chosen_r <= chosen_nxt;
    bucket_r <= bucket_nxt;
    if (out_load) begin
      out_stat_r   <= stat_r;
      out_chosen_r <= chosen_r;
      out_bucket_r <= bucket_r;
    end
  end

  assign in_ch.ready           = (state_r == ST_IDLE);
  assign out_ch.valid          = out_vld_r;
  assign out_ch.status         = out_stat_r;
  assign out_ch.chosen_backend = out_chosen_r;
  assign out_ch.bucket         = out_bucket_r;
endmodule

>>> src/mlt_checker.sv
// Port-level checks of the maglev table builder, bound to the top level
`include "maglev_lookup_table_builder_unit_defines.svh"

module mlt_checker (
  input logic       clk,
  input logic       rst_n,
  input logic       in_valid,
  input logic       in_ready,
  input logic       out_valid,
  input logic       out_ready,
  input logic [1:0] out_status
);
  import mlt_pkg::*;

  // a result held back by the sink stays offered
  `MLT_ASSERT(a_out_hold, clk, rst_n, out_valid && !out_ready |=> out_valid, "result dropped")
  // one item at a time: no second accept straight after one
  `MLT_ASSERT(a_one_item, clk, rst_n, in_valid && in_ready |=> !in_ready, "ready after accept")
  // the slot sweep after reset keeps the input closed
  `MLT_ASSERT_ALWAYS(a_rst_sweep, clk, rst_n && !$past(rst_n) |-> !in_ready, "ready in sweep")
  // status carries only defined codes
  `MLT_ASSERT(a_status, clk, rst_n, out_valid |-> out_status != 2'd3, "bad status")
endmodule

bind maglev_lookup_table_builder_unit mlt_checker u_mlt_checker (
  .clk        (clk),
  .rst_n      (rst_n),
  .in_valid   (in_ch.valid),
  .in_ready   (in_ch.ready),
  .out_valid  (out_ch.valid),
  .out_ready  (out_ch.ready),
  .out_status (out_ch.status)
);
